### sv/rscc_pkg.sv
// ----------------------------------------------------------------------------
// rscc_pkg
// Shared constants and types for the MIDI running-status CC decoder.
// ----------------------------------------------------------------------------
package rscc_pkg;

    // Default sizes of the send matrix
    localparam int unsigned NUM_SENDS_DEF  = 3;
    localparam int unsigned NUM_TRACKS_DEF = 8;

    // Byte classes
    localparam logic [7:0] REALTIME_MIN   = 8'hF8;
    localparam logic [7:0] SYS_COMMON_MIN = 8'hF0;

    // Real-time bytes that produce transport events
    localparam logic [7:0] RT_CLOCK    = 8'hF8;
    localparam logic [7:0] RT_START    = 8'hFA;
    localparam logic [7:0] RT_CONTINUE = 8'hFB;
    localparam logic [7:0] RT_STOP     = 8'hFC;

    // Status high nibbles
    localparam logic [3:0] HI_CTRL_CHANGE = 4'hB;
    localparam logic [3:0] HI_PROG_CHANGE = 4'hC;
    localparam logic [3:0] HI_CHAN_PRESS  = 4'hD;

    // Controller numbers and thresholds
    localparam logic [6:0] SEND_BASE_CC  = 7'd20;
    localparam logic [6:0] SONG_CC       = 7'd102;
    localparam logic [6:0] ARM_THRESHOLD = 7'd64;

    // Configuration port
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_ARM_CONTROLLER  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ARM_CHANNEL_SEL = 2'd1;

    typedef enum logic [2:0] {
        KIND_MSG      = 3'd0,
        KIND_CLOCK    = 3'd1,
        KIND_START    = 3'd2,
        KIND_CONTINUE = 3'd3,
        KIND_STOP     = 3'd4
    } t_event_kind;

    // Assembled message handed from the parser to the CC decode stage
    typedef struct packed {
        t_event_kind kind;
        logic [7:0]  status;
        logic [6:0]  first;
        logic [6:0]  second;
        logic [1:0]  length;
    } t_msg;

    // Final result item
    typedef struct packed {
        t_event_kind kind;
        logic [7:0]  status;
        logic [6:0]  first;
        logic [6:0]  second;
        logic [1:0]  length;
        logic        arm_update;
        logic        armed_level;
        logic        send_update;
        logic [2:0]  send_track;
        logic [1:0]  send_bus;
        logic        song_request;
    } t_result;

endpackage

### sv/rscc_byte_if.sv
// ----------------------------------------------------------------------------
// rscc_byte_if
// Valid/ready channel carrying one raw MIDI byte per transaction.
// ----------------------------------------------------------------------------
interface rscc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;

    modport source (output valid, output byte_in, input ready);
    modport sink   (input valid, input byte_in, output ready);
endinterface

### sv/rscc_evt_if.sv
// ----------------------------------------------------------------------------
// rscc_evt_if
// Valid/ready channel carrying one decoded MIDI event per transaction.
// ----------------------------------------------------------------------------
interface rscc_evt_if;
    logic       valid;
    logic       ready;
    logic [2:0] event_kind;
    logic [7:0] msg_status;
    logic [6:0] msg_first;
    logic [6:0] msg_second;
    logic [1:0] msg_length;
    logic       arm_update;
    logic       armed_level;
    logic       send_update;
    logic [2:0] send_track;
    logic [1:0] send_bus;
    logic       song_request;

    modport source (
        output valid, output event_kind, output msg_status, output msg_first,
        output msg_second, output msg_length, output arm_update, output armed_level,
        output send_update, output send_track, output send_bus, output song_request,
        input ready
    );
    modport sink (
        input valid, input event_kind, input msg_status, input msg_first,
        input msg_second, input msg_length, input arm_update, input armed_level,
        input send_update, input send_track, input send_bus, input song_request,
        output ready
    );
endinterface

### sv/rscc_cfg_if.sv
// ----------------------------------------------------------------------------
// rscc_cfg_if
// Register write channel: index and data, one write per transaction.
// ----------------------------------------------------------------------------
interface rscc_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [rscc_pkg::CFG_IDX_W-1:0]   index;
    logic [rscc_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### sv/rscc_parser.sv
// ----------------------------------------------------------------------------
// rscc_parser
// Byte-level MIDI parser: keeps running status and the first data byte,
// and registers each complete channel message or transport event.
// ----------------------------------------------------------------------------
module rscc_parser (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [7:0]      i_byte,
    input  logic            i_valid,
    output logic            o_ready,
    output rscc_pkg::t_msg  o_msg,
    output logic            o_valid,
    input  logic            i_ready
);

    logic [7:0]     r_status;
    logic [1:0]     r_exp;
    logic           r_recv;
    logic [6:0]     r_first;
    logic           r_valid;
    rscc_pkg::t_msg r_msg;

    logic [7:0]     n_status;
    logic [1:0]     n_exp;
    logic           n_recv;
    logic [6:0]     n_first;
    rscc_pkg::t_msg w_msg;
    logic           w_emit;
    logic           w_acc;

    // Take a byte whenever the message register is free or being drained
    assign o_ready = !r_valid || i_ready;
    assign w_acc   = i_valid && o_ready;
    assign o_valid = r_valid;
    assign o_msg   = r_msg;

    // Classify the byte and advance the parser state
    always_comb begin
        n_status      = r_status;
        n_exp         = r_exp;
        n_recv        = r_recv;
        n_first       = r_first;
        w_emit        = 1'b0;
        w_msg         = '0;
        w_msg.kind    = rscc_pkg::KIND_MSG;
        if (i_byte >= rscc_pkg::REALTIME_MIN) begin
            // Real-time: transport events only, running status untouched
            case (i_byte)
                rscc_pkg::RT_CLOCK: begin
                    w_emit     = 1'b1;
                    w_msg.kind = rscc_pkg::KIND_CLOCK;
                end
                rscc_pkg::RT_START: begin
                    w_emit     = 1'b1;
                    w_msg.kind = rscc_pkg::KIND_START;
                end
                rscc_pkg::RT_CONTINUE: begin
                    w_emit     = 1'b1;
                    w_msg.kind = rscc_pkg::KIND_CONTINUE;
                end
                rscc_pkg::RT_STOP: begin
                    w_emit     = 1'b1;
                    w_msg.kind = rscc_pkg::KIND_STOP;
                end
                default: begin
                end
            endcase
        end else if (i_byte[7]) begin
            if (i_byte >= rscc_pkg::SYS_COMMON_MIN) begin
                // System common: drop running status
                n_status = '0;
                n_exp    = '0;
                n_recv   = 1'b0;
            end else begin
                n_status = i_byte;
                n_recv   = 1'b0;
                case (i_byte[7:4]) inside
                    rscc_pkg::HI_PROG_CHANGE, rscc_pkg::HI_CHAN_PRESS: n_exp = 2'd1;
                    default: n_exp = 2'd2;
                endcase
            end
        end else if (r_status[7]) begin
            // Data byte under running status
            w_msg.status = r_status;
            w_msg.length = 2'(r_exp + 2'd1);
            if (!r_recv) begin
                n_first = i_byte[6:0];
                if (r_exp == 2'd1) begin
                    w_emit      = 1'b1;
                    w_msg.first = i_byte[6:0];
                end else begin
                    n_recv = 1'b1;
                end
            end else begin
                n_recv       = 1'b0;
                w_emit       = 1'b1;
                w_msg.first  = r_first;
                w_msg.second = i_byte[6:0];
            end
        end
    end

    // Parser state and message register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_status <= '0;
            r_exp    <= '0;
            r_recv   <= 1'b0;
            r_first  <= '0;
            r_valid  <= 1'b0;
        end else begin
            if (w_acc) begin
                r_status <= n_status;
                r_exp    <= n_exp;
                r_recv   <= n_recv;
                r_first  <= n_first;
            end
            if (o_ready) begin
                r_valid <= w_acc && w_emit;
            end
        end
    end

    // Load the message payload
    always_ff @(posedge i_clk) begin
        if (w_acc && w_emit) begin
            r_msg <= w_msg;
        end
    end

`ifndef ASSERT_OFF
    a_recv_needs_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_recv |-> (r_status[7] && r_exp == 2'd2))
        else $error("first data byte held without a two-byte running status");

    a_transport_blank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_msg.kind != rscc_pkg::KIND_MSG)
            |-> (r_msg.length == 2'd0 && r_msg.status == 8'd0))
        else $error("transport event carries message fields");
`endif

endmodule

### sv/rscc_decode.sv
// ----------------------------------------------------------------------------
// rscc_decode
// Control-change decode: arm, send-level and song-request flags, registered
// into the result stage.
// ----------------------------------------------------------------------------
module rscc_decode #(
    parameter int unsigned NUM_SENDS  = rscc_pkg::NUM_SENDS_DEF,
    parameter int unsigned NUM_TRACKS = rscc_pkg::NUM_TRACKS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rscc_pkg::t_msg    i_msg,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [6:0]        i_arm_controller,
    input  logic [4:0]        i_arm_channel_sel,
    output rscc_pkg::t_result o_res,
    output logic              o_valid,
    input  logic              i_ready
);

    logic              r_valid;
    rscc_pkg::t_result r_res;
    rscc_pkg::t_result w_res;

    logic       w_is_cc;
    logic [4:0] w_chan;
    logic [6:0] w_cc_off;
    logic       w_arm;
    logic       w_send;
    logic       w_acc;

    assign o_ready = !r_valid || i_ready;
    assign w_acc   = i_valid && o_ready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    // Decode the controller against config and the send matrix
    assign w_is_cc  = (i_msg.status[7:4] == rscc_pkg::HI_CTRL_CHANGE);
    assign w_chan   = {1'b0, i_msg.status[3:0]} + 5'd1;
    assign w_cc_off = i_msg.first - rscc_pkg::SEND_BASE_CC;
    assign w_arm    = w_is_cc && (i_msg.first == i_arm_controller)
                      && (i_arm_channel_sel == 5'd0 || w_chan == i_arm_channel_sel);
    assign w_send   = w_is_cc && (i_msg.first >= rscc_pkg::SEND_BASE_CC)
                      && ({1'b0, w_cc_off} < 8'(NUM_SENDS))
                      && (w_chan <= 5'(NUM_TRACKS));

    always_comb begin
        w_res              = '0;
        w_res.kind         = i_msg.kind;
        w_res.status       = i_msg.status;
        w_res.first        = i_msg.first;
        w_res.second       = i_msg.second;
        w_res.length       = i_msg.length;
        w_res.arm_update   = w_arm;
        w_res.armed_level  = w_arm && (i_msg.second >= rscc_pkg::ARM_THRESHOLD);
        w_res.send_update  = w_send;
        w_res.send_track   = w_send ? i_msg.status[2:0] : 3'd0;
        w_res.send_bus     = w_send ? w_cc_off[1:0] : 2'd0;
        w_res.song_request = w_is_cc && (i_msg.first == rscc_pkg::SONG_CC);
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_res <= w_res;
        end
    end

`ifndef ASSERT_OFF
    a_arm_is_cc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && (r_res.arm_update || r_res.send_update || r_res.song_request))
            |-> (r_res.kind == rscc_pkg::KIND_MSG && r_res.length == 2'd3))
        else $error("control-change flag on a non control-change event");

    a_level_needs_arm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_res.armed_level) |-> r_res.arm_update)
        else $error("armed level set without an arm update");

    a_track_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_res.send_update) |-> (5'(r_res.send_track) < 5'(NUM_TRACKS)))
        else $error("send track beyond configured track count");
`endif

endmodule

### sv/midi_running_status_cc_decoder.sv
// ----------------------------------------------------------------------------
// midi_running_status_cc_decoder
// Raw MIDI byte stream to channel-message and transport events, with
// control-change decoding for recorder arm, track sends and song requests.
// ----------------------------------------------------------------------------
// Takes one MIDI byte per clock and, with the result side ready, sustains one
// byte every cycle; a result is held first in the parser message register and
// then in the CC decode result register on its way to the sink. Each
// stage accepts as soon as its register is empty or being drained, so the
// input stalls only when both stages hold results the sink has not taken.
// Configuration writes are always accepted and must only happen while the
// pipeline is empty.
// ----------------------------------------------------------------------------
module midi_running_status_cc_decoder #(
    parameter int unsigned NUM_SENDS  = rscc_pkg::NUM_SENDS_DEF,
    parameter int unsigned NUM_TRACKS = rscc_pkg::NUM_TRACKS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rscc_byte_if.sink  i_byte,
    rscc_evt_if.source o_evt,
    rscc_cfg_if.sink   i_cfg
);

    logic [6:0]        r_arm_controller;
    logic [4:0]        r_arm_channel_sel;

    rscc_pkg::t_msg    w_msg;
    logic              w_msg_valid;
    logic              w_msg_ready;
    rscc_pkg::t_result w_res;

    // Configuration registers
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_arm_controller  <= '0;
            r_arm_channel_sel <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                rscc_pkg::CFG_ARM_CONTROLLER:  r_arm_controller  <= i_cfg.data[6:0];
                rscc_pkg::CFG_ARM_CHANNEL_SEL: r_arm_channel_sel <= i_cfg.data[4:0];
                default: begin
                end
            endcase
        end
    end

    // Byte parser
    rscc_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (i_byte.byte_in),
        .i_valid (i_byte.valid),
        .o_ready (i_byte.ready),
        .o_msg   (w_msg),
        .o_valid (w_msg_valid),
        .i_ready (w_msg_ready)
    );

    // Control-change decode and result register
    rscc_decode #(
        .NUM_SENDS  (NUM_SENDS),
        .NUM_TRACKS (NUM_TRACKS)
    ) u_decode (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_msg             (w_msg),
        .i_valid           (w_msg_valid),
        .o_ready           (w_msg_ready),
        .i_arm_controller  (r_arm_controller),
        .i_arm_channel_sel (r_arm_channel_sel),
        .o_res             (w_res),
        .o_valid           (o_evt.valid),
        .i_ready           (o_evt.ready)
    );

    // Drive the event channel
    assign o_evt.event_kind   = 3'(w_res.kind);
    assign o_evt.msg_status   = w_res.status;
    assign o_evt.msg_first    = w_res.first;
    assign o_evt.msg_second   = w_res.second;
    assign o_evt.msg_length   = w_res.length;
    assign o_evt.arm_update   = w_res.arm_update;
    assign o_evt.armed_level  = w_res.armed_level;
    assign o_evt.send_update  = w_res.send_update;
    assign o_evt.send_track   = w_res.send_track;
    assign o_evt.send_bus     = w_res.send_bus;
    assign o_evt.song_request = w_res.song_request;

endmodule

### tb/midi_running_status_cc_decoder_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midi_running_status_cc_decoder_test
// Self-checking bench for the MIDI running-status CC decoder.
// ----------------------------------------------------------------------------
// Feeds raw MIDI bytes over the byte channel. A short table of directed bytes
// comes first. Random traffic follows in several register settings, and most
// of it is well-formed channel messages with real-time bytes mixed in. A
// local parser tracks running status and the arm registers and queues the
// expected events. Each event taken from the block is compared field by field
// with the oldest queued one. Both sides idle at random, one phase runs with
// no gaps, and in one phase the sink holds off long enough to stall the input.
// ----------------------------------------------------------------------------
module midi_running_status_cc_decoder_test;

    localparam int unsigned SEND_COUNT     = rscc_pkg::NUM_SENDS_DEF;
    localparam int unsigned TRACK_COUNT    = rscc_pkg::NUM_TRACKS_DEF;
    localparam int unsigned IDLE_PCT       = 21;
    localparam int unsigned SETTLE_CYCLES  = 6;
    localparam int unsigned SINK_HOLD      = 150;
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned PHASE_COUNT    = 5;
    localparam int unsigned PHASE_BYTES    = 215;
    localparam int unsigned STEADY_PHASE   = 3;
    localparam int unsigned HOLD_PHASE     = 1;

    // Indexes past the register list; writes there must be dropped
    localparam logic [rscc_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE_LO = 2'd2;
    localparam logic [rscc_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE_HI = 2'd3;

    localparam rscc_pkg::t_result NO_EVENT = '{rscc_pkg::KIND_MSG, 8'h00, 7'h00, 7'h00, 2'd0,
                                     1'b0, 1'b0, 1'b0, 3'd0, 2'd0, 1'b0};
    localparam rscc_pkg::t_result EV_CLOCK = '{rscc_pkg::KIND_CLOCK, 8'h00, 7'h00, 7'h00, 2'd0,
                                     1'b0, 1'b0, 1'b0, 3'd0, 2'd0, 1'b0};
    localparam rscc_pkg::t_result EV_START = '{rscc_pkg::KIND_START, 8'h00, 7'h00, 7'h00, 2'd0,
                                     1'b0, 1'b0, 1'b0, 3'd0, 2'd0, 1'b0};
    localparam rscc_pkg::t_result EV_CONT  = '{rscc_pkg::KIND_CONTINUE, 8'h00, 7'h00, 7'h00,
                                     2'd0, 1'b0, 1'b0, 1'b0, 3'd0, 2'd0, 1'b0};
    localparam rscc_pkg::t_result EV_STOP  = '{rscc_pkg::KIND_STOP, 8'h00, 7'h00, 7'h00, 2'd0,
                                     1'b0, 1'b0, 1'b0, 3'd0, 2'd0, 1'b0};
    // Note on, channel 1: key 0 full velocity, then key 127 zero velocity
    localparam rscc_pkg::t_result EV_NOTE_LO = '{rscc_pkg::KIND_MSG, 8'h90, 7'h00, 7'h7F, 2'd3,
                                       1'b0, 1'b0, 1'b0, 3'd0, 2'd0, 1'b0};
    localparam rscc_pkg::t_result EV_NOTE_HI = '{rscc_pkg::KIND_MSG, 8'h90, 7'h7F, 7'h00, 2'd3,
                                       1'b0, 1'b0, 1'b0, 3'd0, 2'd0, 1'b0};

    typedef struct packed {
        logic [7:0]        data;
        bit                has_want;
        rscc_pkg::t_result want;
    } t_byte_step;

    localparam int unsigned DIRECTED_LEN = 26;
    localparam t_byte_step DIRECTED_STEPS [DIRECTED_LEN] = '{
        '{8'h45, 1'b0, NO_EVENT},   // data with no running status
        '{8'hF8, 1'b1, EV_CLOCK},
        '{8'hFA, 1'b1, EV_START},
        '{8'hFB, 1'b1, EV_CONT},
        '{8'hFC, 1'b1, EV_STOP},
        '{8'hF9, 1'b0, NO_EVENT},   // unused real-time bytes
        '{8'hFF, 1'b0, NO_EVENT},
        '{8'h90, 1'b0, NO_EVENT},
        '{8'h00, 1'b0, NO_EVENT},
        '{8'h7F, 1'b1, EV_NOTE_LO},
        '{8'h7F, 1'b0, NO_EVENT},   // running status reuse
        '{8'h00, 1'b1, EV_NOTE_HI},
        '{8'hB0, 1'b0, NO_EVENT},   // CC 0 on channel 1, clock in between
        '{8'h00, 1'b0, NO_EVENT},
        '{8'hF8, 1'b1, EV_CLOCK},
        '{8'h7F, 1'b0, NO_EVENT},
        '{8'hCF, 1'b0, NO_EVENT},   // program change, one data byte
        '{8'h7F, 1'b0, NO_EVENT},
        '{8'hF2, 1'b0, NO_EVENT},   // system common clears running status
        '{8'h10, 1'b0, NO_EVENT},
        '{8'hB7, 1'b0, NO_EVENT},   // send level, channel 8, last bus
        '{8'h16, 1'b0, NO_EVENT},
        '{8'h3F, 1'b0, NO_EVENT},
        '{8'hB0, 1'b0, NO_EVENT},   // song request
        '{8'h66, 1'b0, NO_EVENT},
        '{8'h05, 1'b0, NO_EVENT}
    };

    logic i_clk;
    logic i_rst_n;

    rscc_byte_if byte_bus ();
    rscc_evt_if  evt_bus ();
    rscc_cfg_if  cfg_bus ();

    midi_running_status_cc_decoder #(
        .NUM_SENDS  (SEND_COUNT),
        .NUM_TRACKS (TRACK_COUNT)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (byte_bus),
        .o_evt   (evt_bus),
        .i_cfg   (cfg_bus)
    );

    // Parser state and register shadows
    logic [7:0] run_status;
    logic [1:0] data_needed;
    logic [1:0] data_seen;
    logic [6:0] first_data_byte;
    logic [6:0] arm_ctrl_shadow;
    logic [4:0] arm_sel_shadow;

    rscc_pkg::t_result expected_events [$];
    int unsigned       fail_count;
    int unsigned       bytes_sent;
    bit                steady_flow;
    bit                hold_request;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Build a channel message event from the parser state
    function automatic rscc_pkg::t_result decode_channel_msg(input logic [6:0] second);
        rscc_pkg::t_result ev;
        logic [4:0]        chan;
        logic [6:0]        cc;
        ev        = NO_EVENT;
        ev.status = run_status;
        ev.first  = first_data_byte;
        ev.second = second;
        ev.length = data_needed + 2'd1;
        chan      = {1'b0, run_status[3:0]} + 5'd1;
        cc        = first_data_byte;
        if (run_status[7:4] == rscc_pkg::HI_CTRL_CHANGE) begin
            if (cc == arm_ctrl_shadow &&
                (arm_sel_shadow == 5'd0 || chan == arm_sel_shadow)) begin
                ev.arm_update  = 1'b1;
                ev.armed_level = (second >= rscc_pkg::ARM_THRESHOLD);
            end
            if (cc >= rscc_pkg::SEND_BASE_CC && (cc - rscc_pkg::SEND_BASE_CC) < SEND_COUNT &&
                chan <= TRACK_COUNT) begin
                ev.send_update = 1'b1;
                ev.send_track  = 3'(chan - 5'd1);
                ev.send_bus    = 2'(cc - rscc_pkg::SEND_BASE_CC);
            end
            if (cc == rscc_pkg::SONG_CC) begin
                ev.song_request = 1'b1;
            end
        end
        return ev;
    endfunction

    // Advance the parser by one byte; return 1 when an event results
    function automatic bit parse_midi_byte(input logic [7:0] b,
                                           output rscc_pkg::t_result ev);
        ev = NO_EVENT;
        if (b >= rscc_pkg::REALTIME_MIN) begin
            case (b)
                rscc_pkg::RT_CLOCK:    ev = EV_CLOCK;
                rscc_pkg::RT_START:    ev = EV_START;
                rscc_pkg::RT_CONTINUE: ev = EV_CONT;
                rscc_pkg::RT_STOP:     ev = EV_STOP;
                default:               return 1'b0;
            endcase
            return 1'b1;
        end
        if (b[7]) begin
            if (b >= rscc_pkg::SYS_COMMON_MIN) begin
                run_status  = 8'h00;
                data_needed = 2'd0;
                data_seen   = 2'd0;
            end else begin
                run_status  = b;
                data_seen   = 2'd0;
                data_needed = (b[7:4] == rscc_pkg::HI_PROG_CHANGE ||
                               b[7:4] == rscc_pkg::HI_CHAN_PRESS) ? 2'd1 : 2'd2;
            end
            return 1'b0;
        end
        if (run_status == 8'h00 || data_needed == 2'd0) begin
            return 1'b0;
        end
        if (data_seen == 2'd0) begin
            first_data_byte = b[6:0];
            data_seen       = 2'd1;
            if (data_needed > 2'd1) begin
                return 1'b0;
            end
            data_seen = 2'd0;
            ev        = decode_channel_msg(7'd0);
            return 1'b1;
        end
        data_seen = 2'd0;
        ev        = decode_channel_msg(b[6:0]);
        return 1'b1;
    endfunction

    // Offer one byte, hold it until taken, then queue what it should produce
    task automatic push_byte(input logic [7:0] b, input bit use_given = 1'b0,
                             input rscc_pkg::t_result given = NO_EVENT);
        rscc_pkg::t_result ev;
        bit                has_ev;
        if (!steady_flow) begin
            while ($urandom_range(99) < IDLE_PCT) begin
                byte_bus.valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        byte_bus.valid   <= 1'b1;
        byte_bus.byte_in <= b;
        @(posedge i_clk);
        while (!byte_bus.ready) @(posedge i_clk);
        bytes_sent++;
        has_ev = parse_midi_byte(b, ev);
        if (use_given) begin
            expected_events.push_back(given);
        end else if (has_ev) begin
            expected_events.push_back(ev);
        end
    endtask

    // Write one register once the pipeline has drained
    task automatic write_reg(input logic [rscc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [rscc_pkg::CFG_DATA_W-1:0] data);
        while (expected_events.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= data;
        @(posedge i_clk);
        while (!cfg_bus.ready) @(posedge i_clk);
        cfg_bus.valid <= 1'b0;
        case (idx)
            rscc_pkg::CFG_ARM_CONTROLLER:  arm_ctrl_shadow = data[6:0];
            rscc_pkg::CFG_ARM_CHANNEL_SEL: arm_sel_shadow  = data[4:0];
            default: ;
        endcase
    endtask

    // Channel message; status 0 reuses running status
    task automatic send_channel_msg(input logic [7:0] status, input logic [6:0] d1,
                                    input logic [6:0] d2);
        logic [3:0] hi;
        hi = (status != 8'h00) ? status[7:4] : run_status[7:4];
        if (status != 8'h00) begin
            push_byte(status);
        end
        if ($urandom_range(99) < 8) push_byte(8'(rscc_pkg::REALTIME_MIN + $urandom_range(7)));
        push_byte({1'b0, d1});
        if (hi != rscc_pkg::HI_PROG_CHANGE && hi != rscc_pkg::HI_CHAN_PRESS) begin
            if ($urandom_range(99) < 8) begin
                push_byte(8'(rscc_pkg::REALTIME_MIN + $urandom_range(7)));
            end
            push_byte({1'b0, d2});
        end
    endtask

    // One random chunk of traffic
    task automatic send_random_chunk();
        int unsigned pick;
        logic [7:0]  status;
        logic [3:0]  chan;
        logic [6:0]  cc;
        logic [6:0]  value;
        pick = $urandom_range(99);
        if (pick < 40) begin
            status = {1'b1, 3'($urandom_range(6)), 4'($urandom_range(15))};
            if (run_status != 8'h00 && data_needed != 2'd0 && $urandom_range(3) == 0) begin
                status = 8'h00;
            end
            send_channel_msg(status, 7'($urandom_range(127)), 7'($urandom_range(127)));
        end else if (pick < 65) begin
            case ($urandom_range(3))
                0:       chan = 4'($urandom_range(15));
                1:       chan = 4'($urandom_range(TRACK_COUNT - 1));
                default: chan = (arm_sel_shadow >= 5'd1 && arm_sel_shadow <= 5'd16) ?
                                4'(arm_sel_shadow - 5'd1) : 4'($urandom_range(15));
            endcase
            case ($urandom_range(5))
                0:       cc = arm_ctrl_shadow;
                1:       cc = 7'(rscc_pkg::SEND_BASE_CC + $urandom_range(SEND_COUNT));
                2:       cc = rscc_pkg::SONG_CC;
                3:       cc = rscc_pkg::SEND_BASE_CC - 7'd1;
                default: cc = 7'($urandom_range(127));
            endcase
            value = $urandom_range(1) ? 7'($urandom_range(127)) :
                    7'(rscc_pkg::ARM_THRESHOLD - 7'd1 + 7'($urandom_range(1)));
            status = {rscc_pkg::HI_CTRL_CHANGE, chan};
            if (run_status == status && data_seen == 2'd0 && $urandom_range(1) == 0) begin
                status = 8'h00;
            end
            send_channel_msg(status, cc, value);
        end else if (pick < 75) begin
            push_byte(8'(rscc_pkg::REALTIME_MIN + $urandom_range(7)));
        end else if (pick < 80) begin
            push_byte(8'(rscc_pkg::SYS_COMMON_MIN + $urandom_range(7)));
        end else if (pick < 90) begin
            push_byte(8'($urandom_range(127)));
        end else begin
            push_byte(8'($urandom_range(255)));
        end
    endtask

    // Sink ready: random gaps, one long hold-off on request
    initial begin : sink_ready_gen
        int unsigned hold_left;
        hold_left     = 0;
        evt_bus.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = SINK_HOLD;
            end
            if (hold_left != 0) begin
                hold_left--;
                evt_bus.ready <= 1'b0;
            end else begin
                evt_bus.ready <= steady_flow || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endfunction

    // Compare each event taken with the oldest expectation
    always @(posedge i_clk) begin : evt_monitor
        rscc_pkg::t_result want;
        if (i_rst_n && evt_bus.valid && evt_bus.ready) begin
            if (expected_events.size() == 0) begin
                $error("unexpected event: kind %0d status 0x%0h",
                       evt_bus.event_kind, evt_bus.msg_status);
                fail_count++;
            end else begin
                want = expected_events.pop_front();
                check_field("event_kind",   8'(want.kind),         8'(evt_bus.event_kind));
                check_field("msg_status",   want.status,           evt_bus.msg_status);
                check_field("msg_first",    8'(want.first),        8'(evt_bus.msg_first));
                check_field("msg_second",   8'(want.second),       8'(evt_bus.msg_second));
                check_field("msg_length",   8'(want.length),       8'(evt_bus.msg_length));
                check_field("arm_update",   8'(want.arm_update),   8'(evt_bus.arm_update));
                check_field("armed_level",  8'(want.armed_level),  8'(evt_bus.armed_level));
                check_field("send_update",  8'(want.send_update),  8'(evt_bus.send_update));
                check_field("send_track",   8'(want.send_track),   8'(evt_bus.send_track));
                check_field("send_bus",     8'(want.send_bus),     8'(evt_bus.send_bus));
                check_field("song_request", 8'(want.song_request), 8'(evt_bus.song_request));
            end
        end
    end

    // Stop the run when no transaction moves for too long
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((byte_bus.valid && byte_bus.ready) || (evt_bus.valid && evt_bus.ready) ||
                (cfg_bus.valid && cfg_bus.ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("[midi_running_status_cc_decoder] ERROR");
        $finish;
    end

    // Main sequence
    initial begin : stimulus
        int unsigned phase_end;
        i_rst_n          = 1'b0;
        byte_bus.valid   = 1'b0;
        byte_bus.byte_in = 8'h00;
        cfg_bus.valid    = 1'b0;
        cfg_bus.index    = rscc_pkg::CFG_ARM_CONTROLLER;
        cfg_bus.data     = 8'h00;
        run_status       = 8'h00;
        data_needed      = 2'd0;
        data_seen        = 2'd0;
        first_data_byte  = 7'd0;
        arm_ctrl_shadow  = 7'd0;
        arm_sel_shadow   = 5'd0;
        fail_count       = 0;
        bytes_sent       = 0;
        steady_flow      = 1'b0;
        hold_request     = 1'b0;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed bytes under reset register values
        for (int i = 0; i < DIRECTED_LEN; i++) begin
            push_byte(DIRECTED_STEPS[i].data, DIRECTED_STEPS[i].has_want,
                      DIRECTED_STEPS[i].want);
        end
        byte_bus.valid <= 1'b0;

        // Random traffic under several register settings
        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            case (phase)
                0: begin
                    write_reg(rscc_pkg::CFG_ARM_CONTROLLER, 8'hFF);
                    write_reg(rscc_pkg::CFG_ARM_CHANNEL_SEL, 8'd16);
                end
                1: begin
                    write_reg(rscc_pkg::CFG_ARM_CONTROLLER, 8'(rscc_pkg::SEND_BASE_CC));
                    write_reg(rscc_pkg::CFG_ARM_CHANNEL_SEL, 8'd1);
                    write_reg(CFG_IDX_SPARE_LO, 8'h55);
                    write_reg(CFG_IDX_SPARE_HI, 8'hAA);
                end
                2: begin
                    write_reg(rscc_pkg::CFG_ARM_CONTROLLER, {1'b1, rscc_pkg::SONG_CC});
                    write_reg(rscc_pkg::CFG_ARM_CHANNEL_SEL, 8'hFF);
                end
                3: begin
                    write_reg(rscc_pkg::CFG_ARM_CONTROLLER, 8'($urandom_range(255)));
                    write_reg(rscc_pkg::CFG_ARM_CHANNEL_SEL, 8'($urandom_range(16)));
                end
                default: begin
                    write_reg(rscc_pkg::CFG_ARM_CONTROLLER, 8'h00);
                    write_reg(rscc_pkg::CFG_ARM_CHANNEL_SEL, 8'h00);
                end
            endcase
            steady_flow  = (phase == STEADY_PHASE);
            hold_request = (phase == HOLD_PHASE);
            phase_end    = bytes_sent + PHASE_BYTES;
            while (bytes_sent < phase_end) send_random_chunk();
            byte_bus.valid <= 1'b0;
        end

        // Drain, then give the pipeline time to show any stray event
        while (expected_events.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("[midi_running_status_cc_decoder] OK");
        end else begin
            $display("[midi_running_status_cc_decoder] ERROR");
        end
        $finish;
    end

endmodule
